### design/pfa_pkg.sv
// Shared types, codes and field widths of the packed field array.
package pfa_pkg;

  // Field widths
  localparam int OP_W       = 2;
  localparam int IDX_W      = 12;
  localparam int VAL_W      = 8;
  localparam int WL_W       = 2;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Default store size in bytes
  localparam int STORE_BYTES_DEF = 512;

  typedef logic [OP_W-1:0]       op_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [VAL_W-1:0]      val_t;
  typedef logic [WL_W-1:0]       wl_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Operation codes
  localparam op_t OP_GET   = 2'd0;
  localparam op_t OP_SET   = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t CFG_WIDTH_LOG2  = 1'd0;
  localparam cfg_idx_t CFG_VALUE_COUNT = 1'd1;

  // Right-aligned field mask for a given log2 width
  function automatic val_t field_mask(input wl_t wl);
    val_t m;
    case (wl)
      2'd0:    m = 8'h01;
      2'd1:    m = 8'h03;
      2'd2:    m = 8'h0F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

### design/pfa_store.sv
// Byte store of the packed field array with a zeroing sweep after reset.
module pfa_store #(
  parameter int STORE_BYTES = pfa_pkg::STORE_BYTES_DEF,
  parameter int AW          = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output pfa_pkg::val_t        rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  pfa_pkg::val_t        wr_data,
  output logic                 clr_busy
);
  import pfa_pkg::*;

  val_t          mem [0:STORE_BYTES-1];
  val_t          rd_data_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] clr_cnt_nxt;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  val_t          mem_wdata;

  // Sweep counter: one byte zeroed per cycle after reset
  always_comb begin
    clr_cnt_nxt = clr_cnt_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_nxt;
      if (clr_cnt_r == AW'(STORE_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Write port is owned by the sweep while it runs
  always_comb begin
    mem_we    = clr_busy_r | wr_en;
    mem_waddr = clr_busy_r ? clr_cnt_r : wr_addr;
    mem_wdata = clr_busy_r ? '0 : wr_data;
  end

  // Single write port, single registered read port (read returns old data)
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

### design/packed_field_array.sv
// Top level of the packed field array: request decode, read-modify-write, result register.
//
// Usage:
//   A byte store holds packed values of 1, 2, 4 or 8 bits, numbered from the
//   MSB of byte 0. Each transfer on the in_ channel (valid/ready) is a get,
//   set or clear of one value; each yields exactly one transfer on the out_
//   channel carrying read_value and error, in request order.
//   cfg_wr_en writes width_log2 (index 0) or value_count (index 1); write
//   only while no request is in flight.
//   Pipeline: modify stage register, then result register. Throughput: one
//   request per cycle outside the reset sweep and stalls. The byte is read
//   from the memory's registered read port at acceptance and written back as
//   the request leaves the modify stage; a request that hits the byte being
//   written gets the new byte by bypass. Reset: configuration goes to zero and
//   a sweep zeroes the store, one byte per cycle; in_ready stays low during the sweep.
//   Stall: when out_ready is low the result register holds, the request
//   behind it holds (its write-back waits), and in_ready drops once both
//   are full.
module packed_field_array #(
  parameter int STORE_BYTES = pfa_pkg::STORE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  pfa_pkg::op_t        in_operation,
  input  pfa_pkg::idx_t       in_index,
  input  pfa_pkg::val_t       in_new_value,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output pfa_pkg::val_t       out_read_value,
  output logic                out_error,
  // Configuration write port
  input  logic                cfg_wr_en,
  input  pfa_pkg::cfg_idx_t   cfg_index,
  input  pfa_pkg::cfg_data_t  cfg_data
);
  import pfa_pkg::*;

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;

  // Configuration registers
  wl_t  wl_r;
  cnt_t cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r  <= '0;
      cnt_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIDTH_LOG2:  wl_r  <= cfg_data[WL_W-1:0];
        CFG_VALUE_COUNT: cnt_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request decode: byte address, shift, mask, range check
  logic [IDX_W+2:0] bitpos;
  idx_t             byte_addr;
  logic [XW-1:0]    addr_x;
  logic [AW-1:0]    addr0;
  logic [3:0]       wid0;
  logic [2:0]       shift0;
  val_t             mask0;
  logic             err0;

  always_comb begin
    bitpos    = {3'b000, in_index} << wl_r;
    byte_addr = bitpos[IDX_W+2:3];
    addr_x    = XW'(byte_addr);
    addr0     = addr_x[AW-1:0];
    wid0      = 4'd1 << wl_r;
    shift0    = 3'(4'd8 - wid0 - {1'b0, bitpos[2:0]});
    mask0     = field_mask(wl_r) << shift0;
    err0      = ({1'b0, in_index} >= cnt_r) || (32'(byte_addr) >= 32'(STORE_BYTES));
  end

  // Modify stage registers
  logic          s1_vld_r;
  op_t           s1_op_r;
  logic          s1_err_r;
  logic [2:0]    s1_shift_r;
  val_t          s1_mask_r;
  val_t          s1_val_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_byp_r;
  val_t          s1_byp_data_r;

  logic          out_vld_r;
  val_t          out_rd_r;
  logic          out_err_r;

  logic          clr_busy;
  val_t          mem_rdata;
  logic          s1_adv;
  logic          s1_take;
  logic          s1_fire;
  logic          in_fire;
  logic          s1_we;
  logic          byp0;
  val_t          s1_cur;
  val_t          s1_wbyte;
  val_t          s1_rd;

  // Handshake control
  always_comb begin
    s1_adv   = !out_vld_r || out_ready;
    s1_take  = !s1_vld_r || s1_adv;
    in_ready = s1_take && !clr_busy;
    in_fire  = in_valid && in_ready;
    s1_fire  = s1_vld_r && s1_adv;
  end

  // Read-modify-write of the addressed byte
  always_comb begin
    s1_cur   = s1_byp_r ? s1_byp_data_r : mem_rdata;
    s1_rd    = '0;
    s1_wbyte = s1_cur;
    case (s1_op_r)
      OP_GET:   s1_rd    = (s1_cur & s1_mask_r) >> s1_shift_r;
      OP_SET:   s1_wbyte = (s1_cur & ~s1_mask_r) | ((s1_val_r << s1_shift_r) & s1_mask_r);
      OP_CLEAR: s1_wbyte = s1_cur & ~s1_mask_r;
      default:  s1_rd    = '0;
    endcase
    if (s1_err_r) begin
      s1_rd = '0;
    end
    s1_we = s1_fire && !s1_err_r && (s1_op_r == OP_SET || s1_op_r == OP_CLEAR);
    byp0  = s1_we && (s1_addr_r == addr0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_take) begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r       <= in_operation;
      s1_err_r      <= err0;
      s1_shift_r    <= shift0;
      s1_mask_r     <= mask0;
      s1_val_r      <= in_new_value;
      s1_addr_r     <= addr0;
      s1_byp_r      <= byp0;
      s1_byp_data_r <= s1_wbyte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_rd_r  <= s1_rd;
      out_err_r <= s1_err_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_read_value = out_rd_r;
  assign out_error      = out_err_r;

  // Byte store
  pfa_store #(
    .STORE_BYTES (STORE_BYTES),
    .AW          (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr  (addr0),
    .rd_data  (mem_rdata),
    .wr_en    (s1_we),
    .wr_addr  (s1_addr_r),
    .wr_data  (s1_wbyte),
    .clr_busy (clr_busy)
  );

`ifndef ASSERT_OFF
  // No request enters while the store is being zeroed
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready)
    else $error("request accepted during store sweep");

  // An error result never carries data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_err_r) |-> (out_rd_r == '0))
    else $error("error result with nonzero read value");

  // Write-back happens only when the request leaves the modify stage
  a_we_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    s1_we |-> (s1_vld_r && s1_adv && !s1_err_r))
    else $error("store write without stage advance");

  // A stalled request keeps its place, its address and its operation
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> (s1_vld_r && $stable(s1_addr_r) && $stable(s1_op_r)))
    else $error("stalled request lost");
`endif

endmodule

### bench/tb.sv
// Self-checking testbench for packed_field_array: directed and random get/set/clear and unused-op traffic.
`timescale 1ns / 100ps

module tb;
  import pfa_pkg::*;

  localparam int     MEM_BYTES = STORE_BYTES_DEF;
  // Op code 3 has no function; the block must leave the store alone
  localparam op_t    OP_UNUSED = 2'd3;

  typedef struct packed {
    val_t read_value;
    logic error;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  op_t        in_operation = OP_GET;
  idx_t       in_index = '0;
  val_t       in_new_value = '0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  val_t       out_read_value;
  logic       out_error;
  logic       cfg_wr_en = 1'b0;
  cfg_idx_t   cfg_index = CFG_WIDTH_LOG2;
  cfg_data_t  cfg_data = '0;

  // Shadow copy of the store and configuration
  logic [7:0] shadow_mem [MEM_BYTES];
  wl_t        shadow_wl;
  cnt_t       shadow_cnt;

  result_t    pending_results[$];
  int         mismatches = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;
  int         rx_hold = 0;
  int         hot_base = 0;

  packed_field_array u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_index       (in_index),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_error      (out_error),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Apply one access to the shadow store and return the expected result
  function automatic result_t apply_access(op_t op, idx_t idx, val_t nv);
    int unsigned w, bitpos, addr, shift;
    logic [7:0]  fmask;
    result_t     r;
    w      = 1 << shadow_wl;
    bitpos = idx * w;
    addr   = bitpos / 8;
    shift  = 8 - w - (bitpos % 8);
    fmask  = 8'(((1 << w) - 1) << shift);
    r      = '0;
    if (idx >= shadow_cnt || addr >= MEM_BYTES) begin
      r.error = 1'b1;
    end else begin
      case (op)
        OP_GET: begin
          r.read_value = val_t'((shadow_mem[addr] & fmask) >> shift);
        end
        OP_SET: begin
          shadow_mem[addr] = (shadow_mem[addr] & ~fmask) | (8'(int'(nv) << shift) & fmask);
        end
        OP_CLEAR: begin
          shadow_mem[addr] = shadow_mem[addr] & ~fmask;
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  // Send one request; the expectation is queued at the transfer edge
  task automatic send_access(op_t op, idx_t idx, val_t nv);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_index     <= idx;
    in_new_value <= nv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_access(op, idx, nv));
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic load_config(wl_t wl, cnt_t cnt);
    wait_results_done();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WIDTH_LOG2;
    // upper data bits are don't-care for the width register
    cfg_data  <= cfg_data_t'(($urandom_range(0, 2047) << WL_W) | wl);
    @(posedge clk);
    cfg_index <= CFG_VALUE_COUNT;
    cfg_data  <= cnt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_wl  = wl;
    shadow_cnt = cnt;
  endtask

  // Result checker and receiver stall generator
  always @(posedge clk) begin
    result_t want;
    int      n;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result rd=%0h err=%0b",
                                  out_read_value, out_error));
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value)
          report_mismatch($sformatf("read_value got %0h want %0h",
                                    out_read_value, want.read_value));
        if (out_error !== want.error)
          report_mismatch($sformatf("error got %0b want %0b", out_error, want.error));
      end
      n = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (n > 0) begin
        out_ready <= 1'b0;
        rx_hold = n;
      end
    end else if (!out_ready) begin
      rx_hold--;
      if (rx_hold <= 0) out_ready <= 1'b1;
    end
  end

  // Random index: mostly in range, clustered to revisit written fields
  function automatic idx_t pick_index();
    int lim, r, b;
    lim = (MEM_BYTES * 8) >> shadow_wl;
    if (shadow_cnt < lim) lim = shadow_cnt;
    if (lim > 4096) lim = 4096;
    r = $urandom_range(0, 9);
    if (lim == 0 || r == 0) return idx_t'($urandom);
    if (r == 1) begin
      b = lim - 1 + $urandom_range(0, 2);
      return idx_t'((b > 4095) ? 4095 : b);
    end
    if (r <= 5) return idx_t'((hot_base + $urandom_range(0, 15)) % lim);
    return idx_t'($urandom_range(0, lim - 1));
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 3) return OP_GET;
    if (r <= 6) return OP_SET;
    if (r <= 8) return OP_CLEAR;
    return OP_UNUSED;
  endfunction

  task automatic run_random(int n_items);
    for (int i = 0; i < n_items; i++) begin
      // change the hot window and idling now and then
      if (i % 64 == 0) begin
        hot_base   = $urandom_range(0, 4095);
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      send_access(pick_op(), pick_index(), val_t'($urandom));
    end
  endtask

  task automatic do_reset();
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // clearing sweep runs with in_ready low
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
    shadow_wl  = '0;
    shadow_cnt = '0;
  endtask

  task automatic test_directed();
    // zero count after reset: everything is an error
    send_access(OP_GET, 12'd0, 8'h00);
    send_access(OP_SET, 12'hFFF, 8'hFF);
    // byte-wide fields, capacity limits the index
    load_config(2'd3, 13'd4096);
    send_access(OP_SET, 12'd0, 8'hFF);
    send_access(OP_GET, 12'd0, 8'h00);
    send_access(OP_SET, 12'd511, 8'hA5);
    send_access(OP_GET, 12'd511, 8'h00);
    send_access(OP_GET, 12'd512, 8'h00);
    send_access(OP_SET, 12'hFFF, 8'hFF);
    send_access(OP_UNUSED, 12'd511, 8'hFF);
    send_access(OP_UNUSED, 12'hFFF, 8'h00);
    send_access(OP_CLEAR, 12'd0, 8'h00);
    send_access(OP_GET, 12'd0, 8'h00);
    // single bits, count beyond the index range
    load_config(2'd0, 13'h1FFF);
    send_access(OP_SET, 12'd0, 8'hFF);
    send_access(OP_GET, 12'd0, 8'h00);
    send_access(OP_GET, 12'd1, 8'h00);
    send_access(OP_SET, 12'hFFF, 8'h81);
    send_access(OP_GET, 12'hFFF, 8'h00);
    send_access(OP_CLEAR, 12'hFFF, 8'h00);
    send_access(OP_GET, 12'hFFF, 8'h00);
    // two-bit fields, small count and oversized value
    load_config(2'd1, 13'd8);
    send_access(OP_GET, 12'd7, 8'h00);
    send_access(OP_GET, 12'd8, 8'h00);
    send_access(OP_SET, 12'd5, 8'h7E);
    send_access(OP_GET, 12'd5, 8'h00);
  endtask

  task automatic test_random_widths();
    load_config(2'd0, 13'd4096);  run_random(250);
    load_config(2'd1, 13'd2048);  run_random(200);
    load_config(2'd2, 13'd1024);  run_random(200);
    load_config(2'd3, 13'd512);   run_random(200);
    load_config(2'd3, 13'h1FFF);  run_random(150);
    load_config(2'd1, 13'd100);   run_random(150);
    load_config(2'd0, 13'd4095);  run_random(150);
    load_config(2'd2, 13'd3000);  run_random(150);
    load_config(2'd3, 13'd0);     run_random(50);
  endtask

  // Sender holds off mid-stream until the pipeline is empty
  task automatic test_drain_pause();
    load_config(2'd2, 13'd700);
    run_random(75);
    wait_results_done();
    run_random(75);
  endtask

  initial begin
    do_reset();
    test_directed();
    test_random_widths();
    test_drain_pause();
    wait_results_done();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
design/pfa_pkg.sv
design/pfa_store.sv
design/packed_field_array.sv
bench/tb.sv
